@@ rtl/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared constants, field types, action and status codes for the allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   // Every bitmap row covers a fixed number of slots.
   localparam int ROW_BITS = 64;
   localparam int BIT_W    = 6;
   localparam int BYTE_CNT = ROW_BITS / 8;

   // Field widths of the request and response transactions.
   localparam int SLOT_W   = 12;
   localparam int TARGET_W = 7;
   localparam int STASH_W  = 8;
   localparam int FREE_W   = 13;

   typedef logic [1:0]          action_type;
   typedef logic [1:0]          status_type;
   typedef logic [ROW_BITS-1:0] row_type;

   // Action codes.
   localparam action_type ACT_REFILL      = 2'd0;
   localparam action_type ACT_TAKE        = 2'd1;
   localparam action_type ACT_RELEASE     = 2'd2;
   localparam action_type ACT_RELEASE_ALL = 2'd3;

   // Status codes.
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_EMPTY  = 2'd1;
   localparam status_type ST_DOUBLE = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   // Number of clear bits in one byte of a bitmap row.
   function automatic logic [3:0] zeros_in_byte(input logic [7:0] value);
      logic [3:0] count;
      count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         count = count + {3'd0, ~value[i]};
      end
      return count;
   endfunction

endpackage

@@ rtl/bsa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bitmap_slot_allocator_with_stash_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap slot allocator with stash
// Use bitmap of 64-slot rows, a stash stack of claimed slots and a free count.
// ----------------------------------------------------------------------------
// A request transaction (req_*) carries an action: refill the stash, take one
// slot, release one slot or release every stashed slot. Each request gives
// exactly one response transaction (rsp_*) with the taken slot, the stash
// level, the free-slot count and a status code. Both channels use valid and
// stall; req_stall stays high while a request is being worked on.
// One request is handled at a time by a small sequencer around a bitmap RAM
// and a stash RAM, both with registered reads. A take reads the top of the
// stash; a release reads the slot's row and clears its bit; a release-all
// does that for each stashed slot in turn. A refill skips full rows, counts
// the free bits of each claimed row byte by byte, then steps through its
// bits and pushes each free slot; it ends with a full status when a row
// would overflow the stash. An empty take, an out-of-range release and a
// release-all on an empty stash answer without a RAM access.
// The bit-serial push over each claimed row sets the refill time.
// After reset a clearing pass writes every bitmap row to zero; requests are
// stalled until it ends. The response is held in an output register; while
// the receiver stalls, a finished request waits for that register before
// the next request is accepted.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_with_stash_unit #(
   parameter int BITMAP_ROWS = 64,
   parameter int STASH_DEPTH = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bsa_pkg::action_type          req_action,
   input  logic [bsa_pkg::SLOT_W-1:0]   req_slot_number,
   input  logic [bsa_pkg::TARGET_W-1:0] req_target_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bsa_pkg::SLOT_W-1:0]   rsp_taken_slot,
   output logic [bsa_pkg::STASH_W-1:0]  rsp_stash_count,
   output logic [bsa_pkg::FREE_W-1:0]   rsp_free_count,
   output bsa_pkg::status_type          rsp_status
);

   localparam int RW    = (BITMAP_ROWS > 1) ? $clog2(BITMAP_ROWS) : 1;
   localparam int SAW   = $clog2(STASH_DEPTH);
   localparam int DW    = $clog2(STASH_DEPTH + 1);
   localparam int FW    = $clog2(BITMAP_ROWS * bsa_pkg::ROW_BITS + 1);
   localparam int ENT_W = RW + bsa_pkg::BIT_W;
   localparam int CW    = bsa_pkg::TARGET_W;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_TAKE_RD  = 4'd2;
   localparam logic [3:0] S_TAKE_GET = 4'd3;
   localparam logic [3:0] S_REL_RD   = 4'd4;
   localparam logic [3:0] S_REL_WR   = 4'd5;
   localparam logic [3:0] S_ALL_RD   = 4'd6;
   localparam logic [3:0] S_ALL_ROW  = 4'd7;
   localparam logic [3:0] S_ALL_WR   = 4'd8;
   localparam logic [3:0] S_RF_RD    = 4'd9;
   localparam logic [3:0] S_RF_SNAP  = 4'd10;
   localparam logic [3:0] S_RF_CNT   = 4'd11;
   localparam logic [3:0] S_RF_CHK   = 4'd12;
   localparam logic [3:0] S_RF_PUSH  = 4'd13;
   localparam logic [3:0] S_RF_MARK  = 4'd14;
   localparam logic [3:0] S_FINISH   = 4'd15;

   logic [3:0]                  state_ff, state_in;
   logic [RW-1:0]               row_ff, row_in;
   logic [RW-1:0]               seen_ff, seen_in;
   logic [RW-1:0]               last_row_ff, last_row_in;
   logic [DW-1:0]               depth_ff, depth_in;
   logic [FW-1:0]               free_ff, free_in;
   logic [bsa_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [bsa_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [ENT_W-1:0]            taken_ff, taken_in;
   logic [ENT_W-1:0]            ent_ff, ent_in;
   bsa_pkg::status_type         status_ff, status_in;
   bsa_pkg::row_type            snap_ff, snap_in;
   logic [CW-1:0]               avail_ff, avail_in;
   logic [2:0]                  byte_ff, byte_in;
   logic [bsa_pkg::BIT_W-1:0]   bit_ff, bit_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bsa_pkg::SLOT_W-1:0]  rsp_taken_ff, rsp_taken_in;
   logic [bsa_pkg::STASH_W-1:0] rsp_stash_ff, rsp_stash_in;
   logic [bsa_pkg::FREE_W-1:0]  rsp_free_ff, rsp_free_in;
   bsa_pkg::status_type         rsp_status_ff, rsp_status_in;

   // RAM ports.
   logic                        bm_wr_en;
   logic [RW-1:0]               bm_wr_addr;
   bsa_pkg::row_type            bm_wr_data;
   logic [RW-1:0]               bm_rd_addr;
   bsa_pkg::row_type            bm_rd_data;
   logic                        st_wr_en;
   logic [SAW-1:0]              st_wr_addr;
   logic [ENT_W-1:0]            st_wr_data;
   logic [SAW-1:0]              st_rd_addr;
   logic [ENT_W-1:0]            st_rd_data;

   logic                        req_accept;
   logic                        out_free;
   logic [RW-1:0]               row_next;
   logic [RW-1:0]               last_next;
   logic [RW-1:0]               rel_row;
   logic                        rel_in_range;
   logic                        snap_bit;
   logic [DW:0]                 fill_sum;
   logic [RW-1:0]               ent_row;
   logic [RW-1:0]               st_rd_row;

   // Use bitmap: one row per entry.
   bsa_ram #(
      .WIDTH (bsa_pkg::ROW_BITS),
      .DEPTH (BITMAP_ROWS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // Stash stack of claimed slot numbers.
   bsa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (STASH_DEPTH)
   ) u_stash_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // Handshake and helper values.
   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign row_next     = (row_ff == RW'(BITMAP_ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign last_next    = (last_row_ff == RW'(BITMAP_ROWS - 1)) ? '0 : last_row_ff + 1'b1;
   assign rel_row      = RW'(slot_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W]);
   assign rel_in_range = 32'(req_slot_number[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W])
                         < BITMAP_ROWS;
   assign snap_bit     = snap_ff[bit_ff];
   assign fill_sum     = (DW + 1)'(depth_ff) + (DW + 1)'(avail_ff);
   assign ent_row      = ent_ff[ENT_W-1:bsa_pkg::BIT_W];
   assign st_rd_row    = st_rd_data[ENT_W-1:bsa_pkg::BIT_W];

   // Stash RAM: reads always look at the top of the stack, pushes go above it.
   assign st_rd_addr = SAW'(depth_ff - 1'b1);
   assign st_wr_addr = SAW'(depth_ff);
   assign st_wr_data = {row_ff, bit_ff};
   assign st_wr_en   = (state_ff == S_RF_PUSH) && !snap_bit;

   // Bitmap RAM address and write data selection.
   always_comb begin
      bm_rd_addr = row_ff;
      bm_wr_en   = 1'b0;
      bm_wr_addr = row_ff;
      bm_wr_data = '0;
      case (state_ff)
         S_CLEAR: begin
            bm_wr_en = 1'b1;
         end
         S_REL_RD: begin
            bm_rd_addr = rel_row;
         end
         S_REL_WR: begin
            bm_wr_addr = rel_row;
            bm_wr_en   = bm_rd_data[slot_ff[bsa_pkg::BIT_W-1:0]];
            bm_wr_data = bm_rd_data
                         & ~(bsa_pkg::row_type'(1) << slot_ff[bsa_pkg::BIT_W-1:0]);
         end
         S_ALL_ROW: begin
            bm_rd_addr = st_rd_row;
         end
         S_ALL_WR: begin
            bm_wr_addr = ent_row;
            bm_wr_en   = bm_rd_data[ent_ff[bsa_pkg::BIT_W-1:0]];
            bm_wr_data = bm_rd_data
                         & ~(bsa_pkg::row_type'(1) << ent_ff[bsa_pkg::BIT_W-1:0]);
         end
         S_RF_MARK: begin
            bm_wr_en   = 1'b1;
            bm_wr_data = '1;
         end
         default: begin
            bm_rd_addr = row_ff;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      seen_in     = seen_ff;
      last_row_in = last_row_ff;
      depth_in    = depth_ff;
      free_in     = free_ff;
      slot_in     = slot_ff;
      target_in   = target_ff;
      taken_in    = taken_ff;
      ent_in      = ent_ff;
      status_in   = status_ff;
      snap_in     = snap_ff;
      avail_in    = avail_ff;
      byte_in     = byte_ff;
      bit_in      = bit_ff;
      case (state_ff)
         // Clearing pass over the bitmap after reset.
         S_CLEAR: begin
            if (row_ff == RW'(BITMAP_ROWS - 1)) begin
               row_in   = '0;
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         // Accept a request and dispatch on its action.
         S_IDLE: begin
            if (req_accept) begin
               slot_in   = req_slot_number;
               target_in = req_target_count;
               taken_in  = '0;
               status_in = bsa_pkg::ST_OK;
               case (req_action)
                  bsa_pkg::ACT_REFILL: begin
                     row_in   = last_next;
                     seen_in  = '0;
                     state_in = S_RF_RD;
                  end
                  bsa_pkg::ACT_TAKE: begin
                     if (depth_ff == '0) begin
                        status_in = bsa_pkg::ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_TAKE_RD;
                     end
                  end
                  bsa_pkg::ACT_RELEASE: begin
                     state_in = rel_in_range ? S_REL_RD : S_FINISH;
                  end
                  default: begin
                     state_in = (depth_ff == '0) ? S_FINISH : S_ALL_RD;
                  end
               endcase
            end
         end
         S_TAKE_RD: begin
            state_in = S_TAKE_GET;
         end
         S_TAKE_GET: begin
            taken_in = st_rd_data;
            depth_in = depth_ff - 1'b1;
            state_in = S_FINISH;
         end
         S_REL_RD: begin
            state_in = S_REL_WR;
         end
         S_REL_WR: begin
            if (bm_rd_data[slot_ff[bsa_pkg::BIT_W-1:0]]) begin
               free_in = free_ff + 1'b1;
            end else begin
               status_in = bsa_pkg::ST_DOUBLE;
            end
            state_in = S_FINISH;
         end
         // Release-all: pop, read the slot's row, clear its bit.
         S_ALL_RD: begin
            state_in = S_ALL_ROW;
         end
         S_ALL_ROW: begin
            ent_in   = st_rd_data;
            state_in = S_ALL_WR;
         end
         S_ALL_WR: begin
            if (bm_rd_data[ent_ff[bsa_pkg::BIT_W-1:0]]) begin
               free_in = free_ff + 1'b1;
            end else begin
               status_in = bsa_pkg::ST_DOUBLE;
            end
            depth_in = depth_ff - 1'b1;
            state_in = (depth_ff == DW'(1)) ? S_FINISH : S_ALL_RD;
         end
         // Refill: read the next row and skip it when full.
         S_RF_RD: begin
            state_in = S_RF_SNAP;
         end
         S_RF_SNAP: begin
            snap_in  = bm_rd_data;
            avail_in = '0;
            byte_in  = '0;
            if (&bm_rd_data) begin
               if (seen_ff == RW'(BITMAP_ROWS - 1)) begin
                  last_row_in = row_ff;
                  state_in    = S_FINISH;
               end else begin
                  row_in   = row_next;
                  seen_in  = seen_ff + 1'b1;
                  state_in = S_RF_RD;
               end
            end else begin
               state_in = S_RF_CNT;
            end
         end
         // Count the free bits of the row one byte per cycle.
         S_RF_CNT: begin
            avail_in = avail_ff + CW'(bsa_pkg::zeros_in_byte(snap_ff[byte_ff*8 +: 8]));
            byte_in  = byte_ff + 1'b1;
            if (byte_ff == 3'(bsa_pkg::BYTE_CNT - 1)) begin
               state_in = S_RF_CHK;
            end
         end
         // A row that would overflow the stash ends the scan untouched.
         S_RF_CHK: begin
            bit_in = '0;
            if (fill_sum > (DW + 1)'(STASH_DEPTH)) begin
               status_in   = bsa_pkg::ST_FULL;
               last_row_in = row_ff;
               state_in    = S_FINISH;
            end else begin
               state_in = S_RF_PUSH;
            end
         end
         // Push every free slot of the row in ascending order.
         S_RF_PUSH: begin
            if (!snap_bit) begin
               depth_in = depth_ff + 1'b1;
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == '1) begin
               state_in = S_RF_MARK;
            end
         end
         // Mark the row full and decide whether the scan goes on.
         S_RF_MARK: begin
            free_in = free_ff - FW'(avail_ff);
            if ((depth_ff >= DW'(target_ff)) || (seen_ff == RW'(BITMAP_ROWS - 1))) begin
               last_row_in = row_ff;
               state_in    = S_FINISH;
            end else begin
               row_in   = row_next;
               seen_in  = seen_ff + 1'b1;
               state_in = S_RF_RD;
            end
         end
         // Hand the result to the output register once it is free.
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_taken_in  = rsp_taken_ff;
      rsp_stash_in  = rsp_stash_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_status_in = rsp_status_ff;
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_taken_in  = bsa_pkg::SLOT_W'(taken_ff);
         rsp_stash_in  = bsa_pkg::STASH_W'(depth_ff);
         rsp_free_in   = bsa_pkg::FREE_W'(free_ff);
         rsp_status_in = status_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         seen_ff      <= '0;
         last_row_ff  <= '0;
         depth_ff     <= '0;
         free_ff      <= FW'(BITMAP_ROWS * bsa_pkg::ROW_BITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         seen_ff      <= seen_in;
         last_row_ff  <= last_row_in;
         depth_ff     <= depth_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      target_ff     <= target_in;
      taken_ff      <= taken_in;
      ent_ff        <= ent_in;
      status_ff     <= status_in;
      snap_ff       <= snap_in;
      avail_ff      <= avail_in;
      byte_ff       <= byte_in;
      bit_ff        <= bit_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_stash_ff  <= rsp_stash_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken_slot  = rsp_taken_ff;
   assign rsp_stash_count = rsp_stash_ff;
   assign rsp_free_count  = rsp_free_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

@@ sim/bitmap_slot_allocator_with_stash_checker.sv @@
// ----------------------------------------------------------------------------
// Slot allocator reply checker
// Watches the request and response channels of the slot allocator. It keeps
// its own copy of the use bitmap, the stash and the free count, predicts the
// reply to every accepted request and compares each accepted response with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_with_stash_checker
   import bsa_pkg::*;
#(
   parameter int BITMAP_ROWS = 64,
   parameter int STASH_DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  action_type          req_action,
   input  logic [SLOT_W-1:0]   req_slot_number,
   input  logic [TARGET_W-1:0] req_target_count,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [SLOT_W-1:0]   rsp_taken_slot,
   input  logic [STASH_W-1:0]  rsp_stash_count,
   input  logic [FREE_W-1:0]   rsp_free_count,
   input  status_type          rsp_status,
   output int                  failure_count,
   output int                  pending_replies
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_W-1:0]  taken_slot;
      logic [STASH_W-1:0] stash_count;
      logic [FREE_W-1:0]  free_count;
      status_type         status;
   } alloc_reply_t;

   // Predicted allocator state.
   row_type           used_rows [BITMAP_ROWS];
   logic [SLOT_W-1:0] stash_slots [STASH_DEPTH];
   int                stash_level;
   int                row_ptr;
   int                free_total;

   alloc_reply_t      expected_replies [$];
   int                failures;
   int                replies_checked;

   assign failure_count   = failures;
   assign pending_replies = expected_replies.size();

   // Frees one slot in the bitmap; returns zero when the slot was already free.
   function automatic bit free_slot_bit(input logic [SLOT_W-1:0] slot);
      int row;
      int bit_pos;
      row     = slot / ROW_BITS;
      bit_pos = slot % ROW_BITS;
      if (row >= BITMAP_ROWS) begin
         return 1'b1;
      end
      if (!used_rows[row][bit_pos]) begin
         return 1'b0;
      end
      used_rows[row][bit_pos] = 1'b0;
      free_total++;
      return 1'b1;
   endfunction

   // Walks the rows after the saved pointer and claims whole non-full rows
   // until the stash reaches the target, a row would overflow it, or every
   // row has been visited.
   function automatic status_type claim_rows(input int target);
      int         row;
      int         avail;
      bit         done;
      status_type result;
      row    = row_ptr % BITMAP_ROWS;
      result = ST_OK;
      done   = 1'b0;
      for (int step = 0; step < BITMAP_ROWS && !done; step++) begin
         row = (row + 1) % BITMAP_ROWS;
         if (used_rows[row] != '1) begin
            avail = ROW_BITS - $countones(used_rows[row]);
            if (stash_level + avail > STASH_DEPTH) begin
               result = ST_FULL;
               done   = 1'b1;
            end else begin
               for (int b = 0; b < ROW_BITS; b++) begin
                  if (!used_rows[row][b]) begin
                     stash_slots[stash_level] = SLOT_W'(row * ROW_BITS + b);
                     stash_level++;
                  end
               end
               used_rows[row] = '1;
               free_total    -= avail;
               done           = (stash_level >= target);
            end
         end
      end
      row_ptr = row;
      return result;
   endfunction

   // Applies one request to the predicted state and forms its reply.
   function automatic alloc_reply_t predict_reply(input action_type act,
                                                  input logic [SLOT_W-1:0] slot,
                                                  input logic [TARGET_W-1:0] target);
      alloc_reply_t reply;
      reply = '0;
      reply.status = ST_OK;
      case (act)
         ACT_REFILL: begin
            reply.status = claim_rows(int'(target));
         end
         ACT_TAKE: begin
            if (stash_level == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               stash_level--;
               reply.taken_slot = stash_slots[stash_level];
            end
         end
         ACT_RELEASE: begin
            if (!free_slot_bit(slot)) begin
               reply.status = ST_DOUBLE;
            end
         end
         default: begin
            // Release-all skips slots that are already free but still empties the stash.
            while (stash_level > 0) begin
               stash_level--;
               if (!free_slot_bit(stash_slots[stash_level])) begin
                  reply.status = ST_DOUBLE;
               end
            end
         end
      endcase
      reply.stash_count = STASH_W'(stash_level);
      reply.free_count  = FREE_W'(free_total);
      return reply;
   endfunction

   // Compare accepted responses first, then predict for an accepted request.
   always @(posedge clock) begin
      alloc_reply_t want;
      if (reset) begin
         for (int r = 0; r < BITMAP_ROWS; r++) begin
            used_rows[r] = '0;
         end
         stash_level = 0;
         row_ptr     = 0;
         free_total  = BITMAP_ROWS * ROW_BITS;
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_checked++;
            if (expected_replies.size() == 0) begin
               if (failures < 10) begin
                  $display("%0t: response %0d with no request outstanding: slot %0d stash %0d free %0d status %0d",
                           $realtime, replies_checked, rsp_taken_slot, rsp_stash_count,
                           rsp_free_count, rsp_status);
               end
               failures++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_taken_slot !== want.taken_slot || rsp_stash_count !== want.stash_count ||
                   rsp_free_count !== want.free_count || rsp_status !== want.status) begin
                  if (failures < 10) begin
                     $display("%0t: response %0d expected slot %0d stash %0d free %0d status %0d",
                              $realtime, replies_checked, want.taken_slot, want.stash_count,
                              want.free_count, want.status);
                     $display("%0t: response %0d actual   slot %0d stash %0d free %0d status %0d",
                              $realtime, replies_checked, rsp_taken_slot, rsp_stash_count,
                              rsp_free_count, rsp_status);
                  end
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(predict_reply(req_action, req_slot_number,
                                                     req_target_count));
         end
      end
   end

endmodule

@@ sim/bitmap_slot_allocator_with_stash_unit_test.sv @@
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives refill, take, release and release-all transactions into the slot
// allocator with random gaps and random response stalls. A directed opening
// covers the corner cases, a fill phase drains and refills the stash a few
// times, and a random phase releases handed-out slots and refills from the
// gaps.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_with_stash_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import bsa_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int FILL_ROUNDS  = 3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   action_type          req_action;
   logic [SLOT_W-1:0]   req_slot_number;
   logic [TARGET_W-1:0] req_target_count;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SLOT_W-1:0]   rsp_taken_slot;
   logic [STASH_W-1:0]  rsp_stash_count;
   logic [FREE_W-1:0]   rsp_free_count;
   status_type          rsp_status;

   int                  failure_count;
   int                  pending_replies;

   // Stimulus bookkeeping: actions in flight, slots handed out by takes and
   // the levels reported by the latest response.
   action_type          actions_in_flight [$];
   logic [SLOT_W-1:0]   held_slots [$];
   int                  requests_sent;
   int                  responses_seen;
   int                  last_stash;
   int                  last_free;
   int                  sender_calm;
   int                  receiver_calm;

   bitmap_slot_allocator_with_stash_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot_number  (req_slot_number),
      .req_target_count (req_target_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_taken_slot   (rsp_taken_slot),
      .rsp_stash_count  (rsp_stash_count),
      .rsp_free_count   (rsp_free_count),
      .rsp_status       (rsp_status)
   );

   bitmap_slot_allocator_with_stash_checker reply_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot_number  (req_slot_number),
      .req_target_count (req_target_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_taken_slot   (rsp_taken_slot),
      .rsp_stash_count  (rsp_stash_count),
      .rsp_free_count   (rsp_free_count),
      .rsp_status       (rsp_status),
      .failure_count    (failure_count),
      .pending_replies  (pending_replies)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = ~clock;
   end

   // Gap before the next transaction; now and then a stretch with no gaps.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left = int'($urandom_range(8, 40));
      end
      return int'($urandom_range(0, 10));
   endfunction

   // Sends one request transaction and returns at the falling edge after it
   // has been accepted.
   task automatic send_request(input action_type act, input logic [SLOT_W-1:0] slot,
                               input logic [TARGET_W-1:0] target);
      int gap;
      gap = draw_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_slot_number  <= slot;
      req_target_count <= target;
      actions_in_flight.push_back(act);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Holds the request channel idle until every response has come back.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(negedge clock);
      while (responses_seen != requests_sent) @(negedge clock);
   endtask

   function automatic logic [TARGET_W-1:0] random_target();
      if ($urandom_range(0, 3) == 0) begin
         return TARGET_W'($urandom_range(65, 127));
      end
      return TARGET_W'($urandom_range(0, 64));
   endfunction

   // Mostly releases a slot handed out earlier, otherwise any slot at all.
   function automatic logic [SLOT_W-1:0] pick_release_slot();
      int idx;
      logic [SLOT_W-1:0] slot;
      if (held_slots.size() > 0 && $urandom_range(0, 4) != 0) begin
         idx  = int'($urandom_range(0, held_slots.size() - 1));
         slot = held_slots[idx];
         held_slots.delete(idx);
         return slot;
      end
      return SLOT_W'($urandom);
   endfunction

   // Track responses for the stimulus: slots handed out and latest levels.
   always @(posedge clock) begin
      action_type act;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen <= responses_seen + 1;
         last_stash     <= int'(rsp_stash_count);
         last_free      <= int'(rsp_free_count);
         if (actions_in_flight.size() > 0) begin
            act = actions_in_flight.pop_front();
            if (act == ACT_TAKE && rsp_status == ST_OK) begin
               held_slots.push_back(rsp_taken_slot);
            end
         end
      end
   end

   // Response side: random stalls, independent of valid.
   initial begin : receiver
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         gap = draw_gap(receiver_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Watchdog.
   initial begin
      #40_000_000;
      $display("bitmap_slot_allocator_with_stash_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int rounds;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_REFILL;
      req_slot_number  = '0;
      req_target_count = '0;
      requests_sent    = 0;
      responses_seen   = 0;
      last_stash       = 0;
      last_free        = 0;
      sender_calm      = 0;
      receiver_calm    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty stash, double release, zero target, overflow.
      send_request(ACT_TAKE, 12'd0, 7'd0);
      send_request(ACT_RELEASE, 12'd0, 7'd127);
      send_request(ACT_RELEASE_ALL, 12'd4095, 7'd0);
      send_request(ACT_REFILL, 12'd0, 7'd0);
      send_request(ACT_REFILL, 12'd4095, 7'd127);
      send_request(ACT_REFILL, 12'd0, 7'd127);
      send_request(ACT_TAKE, 12'd4095, 7'd64);
      send_request(ACT_RELEASE, 12'd4095, 7'd0);
      // Freeing a stashed slot makes the next release-all meet it already free.
      send_request(ACT_RELEASE, 12'd100, 7'd0);
      send_request(ACT_RELEASE_ALL, 12'd0, 7'd127);
      send_request(ACT_REFILL, 12'd2730, 7'd64);
      send_request(ACT_TAKE, 12'd1365, 7'd85);
      send_request(ACT_TAKE, 12'd0, 7'd42);
      send_request(ACT_RELEASE, 12'd191, 7'd0);
      send_request(ACT_REFILL, 12'd0, 7'd1);
      send_request(ACT_REFILL, 12'd0, 7'd127);
      send_request(ACT_RELEASE_ALL, 12'd0, 7'd0);
      send_request(ACT_REFILL, 12'd0, 7'd127);
      send_request(ACT_TAKE, 12'd0, 7'd0);
      send_request(ACT_RELEASE, 12'd4032, 7'd0);

      // Fill phase: empty the stash by takes and refill it, a few rounds.
      rounds = 0;
      wait_for_replies();
      while (rounds < FILL_ROUNDS) begin
         repeat (last_stash) send_request(ACT_TAKE, SLOT_W'($urandom), random_target());
         wait_for_replies();
         if (last_free == 0) break;
         send_request(ACT_REFILL, SLOT_W'($urandom), 7'd127);
         wait_for_replies();
         rounds++;
      end
      send_request(ACT_REFILL, SLOT_W'($urandom), 7'd127);
      send_request(ACT_TAKE, SLOT_W'($urandom), 7'd0);
      send_request(ACT_REFILL, SLOT_W'($urandom), 7'd0);

      // Random phase: scattered releases of handed-out slots open gaps that
      // refills then collect.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 20) begin
            send_request(ACT_REFILL, SLOT_W'($urandom), random_target());
         end else if (pick < 55) begin
            send_request(ACT_TAKE, SLOT_W'($urandom), random_target());
         end else if (pick < 92) begin
            send_request(ACT_RELEASE, pick_release_slot(), random_target());
         end else begin
            send_request(ACT_RELEASE_ALL, SLOT_W'($urandom), random_target());
         end
         if (n == RANDOM_ITEMS / 2) begin
            wait_for_replies();
         end
      end

      wait_for_replies();
      repeat (200) @(negedge clock);
      if (failure_count == 0 && pending_replies == 0) begin
         $display("bitmap_slot_allocator_with_stash_unit: match");
      end else begin
         $display("bitmap_slot_allocator_with_stash_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bitmap_slot_allocator_with_stash_unit.sv
sim/bitmap_slot_allocator_with_stash_checker.sv
sim/bitmap_slot_allocator_with_stash_unit_test.sv
